// ===== src/pdg_pkg.sv =====
// Shared widths and constants for the projectile drag/gravity step unit.
// No dependencies.
`timescale 1ns / 1ps

package pdg_pkg;

	localparam int unsigned VEL_W  = 32;
	localparam int unsigned POS_W  = 48;
	localparam int unsigned DT_W   = 16;
	localparam int unsigned DRAG_W = 24;

	localparam int unsigned MUL_A_W = 48;
	localparam int unsigned MUL_B_W = 32;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int unsigned MUL_STEPS = MUL_B_W;

	localparam int unsigned ROOT_IN_W = 64;
	localparam int unsigned ROOT_W    = 32;
	localparam int unsigned ROOT_STEPS = ROOT_IN_W / 2;

	localparam int unsigned GDT_W = 20;

	localparam logic [DRAG_W-1:0] DRAG_RESET  = DRAG_W'(16777);
	localparam logic [GDT_W-1:0]  GRAVITY_Q16 = GDT_W'(642908);

	localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
	localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

endpackage

// ===== src/pdg_ifs.sv =====
// Handshake channels of the projectile step unit: item in, result out, config write.
// Depends on pdg_pkg.
`timescale 1ns / 1ps

interface pdg_item_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   cmd;
	logic        [pdg_pkg::DT_W-1:0]        time_step;
	logic signed [pdg_pkg::VEL_W-1:0]       launch_vel_x;
	logic signed [pdg_pkg::VEL_W-1:0]       launch_vel_y;
	logic signed [pdg_pkg::VEL_W-1:0]       launch_vel_z;
	logic signed [pdg_pkg::POS_W-1:0]       launch_pos_x;
	logic signed [pdg_pkg::POS_W-1:0]       launch_pos_y;
	logic signed [pdg_pkg::POS_W-1:0]       launch_pos_z;

	modport source(output valid, cmd, time_step, launch_vel_x, launch_vel_y, launch_vel_z,
		launch_pos_x, launch_pos_y, launch_pos_z, input ready);
	modport sink(input valid, cmd, time_step, launch_vel_x, launch_vel_y, launch_vel_z,
		launch_pos_x, launch_pos_y, launch_pos_z, output ready);
endinterface

interface pdg_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [pdg_pkg::VEL_W-1:0] vel_x;
	logic signed [pdg_pkg::VEL_W-1:0] vel_y;
	logic signed [pdg_pkg::VEL_W-1:0] vel_z;
	logic signed [pdg_pkg::POS_W-1:0] pos_x;
	logic signed [pdg_pkg::POS_W-1:0] pos_y;
	logic signed [pdg_pkg::POS_W-1:0] pos_z;
	logic                             saturated;

	modport source(output valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, saturated,
		input ready);
	modport sink(input valid, vel_x, vel_y, vel_z, pos_x, pos_y, pos_z, saturated,
		output ready);
endinterface

interface pdg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pdg_pkg::DRAG_W-1:0]        drag_coefficient;

	modport source(output valid, drag_coefficient, input ready);
	modport sink(input valid, drag_coefficient, output ready);
endinterface

// ===== src/projectile_drag_gravity_step_unit.sv =====
// Top level: projectile state, step sequencer, shared multiplier and square root.
// Depends on pdg_pkg, pdg_ifs, pdg_smul, pdg_isqrt.
`timescale 1ns / 1ps

// Holds a projectile's velocity (Q16.16) and position (Q32.16) and returns the
// updated state for every item. A launch item loads the state and goes to ST_DONE,
// which registers its result once the output register is free. A step item runs
// twelve passes of the shared shift-add multiplier (three squares, the drag
// factor in two products, g*dt, three drag losses, three position deltas) plus
// one square root, then ST_DONE loads the output register. One item is in work at
// a time; a new item is accepted once the result sits in the output register.
// While the output register still holds an untaken result, the finished item waits
// and the input stays stalled. The drag coefficient may be written at any idle
// moment.

module projectile_drag_gravity_step_unit (
	input  logic               clk,
	input  logic               arst_n,
	pdg_item_if.sink           item,
	pdg_result_if.source       result,
	pdg_cfg_if.sink            cfg
);

	localparam int unsigned VW = pdg_pkg::VEL_W;
	localparam int unsigned PW = pdg_pkg::POS_W;
	localparam int unsigned NV_W = pdg_pkg::MUL_A_W + 2;
	localparam int unsigned SP_W = VW + pdg_pkg::DT_W + 2;
	localparam int unsigned DL_W = SP_W - 17;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_ROOT,
		ST_DRAG,
		ST_DT,
		ST_GRAV,
		ST_LOSS,
		ST_POS,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [VW-1:0]                     vel_q   [3];
	logic [VW-1:0]                     vnew_q  [3];
	logic [PW-1:0]                     pos_q   [3];
	logic [VW-1:0]                     res_vel_q [3];
	logic [PW-1:0]                     res_pos_q [3];
	logic                              res_sat_q;
	logic                              out_valid_q;
	logic [pdg_pkg::DRAG_W-1:0]        drag_q;
	logic [pdg_pkg::DT_W-1:0]          dt_q;
	logic [pdg_pkg::ROOT_IN_W-1:0]     sumsq_q;
	logic [pdg_pkg::MUL_A_W-1:0]       k_q;
	logic [pdg_pkg::GDT_W-1:0]         gdt_q;
	logic [1:0]                        idx_q;
	logic                              sat_q;
	logic                              vneg_q;
	logic                              go_q;
	logic                              rgo_q;
	logic [pdg_pkg::MUL_A_W-1:0]       op_a_q;
	logic [pdg_pkg::MUL_B_W-1:0]       op_b_q;

	logic                              mul_done;
	logic [pdg_pkg::MUL_P_W-1:0]       mul_p;
	logic                              root_done;
	logic [pdg_pkg::ROOT_W-1:0]        root;

	logic [VW-1:0]                     vel_sel;
	logic [VW-1:0]                     mag_next;
	logic [VW:0]                       vsum;
	logic [VW:0]                       vsum_mag;
	logic [NV_W-1:0]                   nv;
	logic [NV_W-1:0]                   lossx;
	logic [NV_W-1:0]                   gdtx;
	logic                              vclip;
	logic [VW-1:0]                     vval;
	logic [SP_W-1:0]                   pm;
	logic [SP_W-1:0]                   sp;
	logic [DL_W-1:0]                   delta;
	logic [PW:0]                       psum;
	logic                              pclip;
	logic [PW-1:0]                     pval;

	pdg_smul u_smul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q),
		.a      (op_a_q),
		.b      (op_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	pdg_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (rgo_q),
		.x      (sumsq_q),
		.done   (root_done),
		.root   (root)
	);

	// next component to issue: head before a rotation, second slot on a rotating edge
	assign vel_sel  = (state_q == ST_SQ || state_q == ST_LOSS) ? vel_q[1] : vel_q[0];
	assign mag_next = vel_sel[VW-1] ? (VW'(0) - vel_sel) : vel_sel;

	assign vsum     = {vel_q[1][VW-1], vel_q[1]} + {vnew_q[1][VW-1], vnew_q[1]};
	assign vsum_mag = vsum[VW] ? ((VW+1)'(0) - vsum) : vsum;

	// drag loss on the head component, and gravity when the head is z (idx_q == 2)
	always_comb begin
		lossx = {2'b00, mul_p[pdg_pkg::MUL_P_W-1:pdg_pkg::MUL_B_W]};
		gdtx  = (idx_q == 2'd2) ? NV_W'(gdt_q) : '0;
		if (vel_q[0][VW-1]) begin
			nv = {{(NV_W-VW){1'b1}}, vel_q[0]} + lossx - gdtx;
		end else begin
			nv = {{(NV_W-VW){1'b0}}, vel_q[0]} - lossx - gdtx;
		end
		vclip = !((&nv[NV_W-1:VW-1]) || !(|nv[NV_W-1:VW-1]));
		vval  = vclip ? (nv[NV_W-1] ? pdg_pkg::VEL_MIN : pdg_pkg::VEL_MAX) : nv[VW-1:0];
	end

	// position delta, floor of (v_old + v_new) * dt / 2^17
	always_comb begin
		pm    = {1'b0, mul_p[SP_W-2:0]};
		sp    = vneg_q ? (SP_W'(0) - pm) : pm;
		delta = sp[SP_W-1:17];
		psum  = {pos_q[0][PW-1], pos_q[0]} + {{(PW+1-DL_W){delta[DL_W-1]}}, delta};
		pclip = psum[PW] ^ psum[PW-1];
		pval  = pclip ? (psum[PW] ? pdg_pkg::POS_MIN : pdg_pkg::POS_MAX) : psum[PW-1:0];
	end

	assign item.ready       = (state_q == ST_IDLE);
	assign cfg.ready        = 1'b1;
	assign result.valid     = out_valid_q;
	assign result.vel_x     = res_vel_q[0];
	assign result.vel_y     = res_vel_q[1];
	assign result.vel_z     = res_vel_q[2];
	assign result.pos_x     = res_pos_q[0];
	assign result.pos_y     = res_pos_q[1];
	assign result.pos_z     = res_pos_q[2];
	assign result.saturated = res_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vel_q       <= '{default: '0};
			vnew_q      <= '{default: '0};
			pos_q       <= '{default: '0};
			res_vel_q   <= '{default: '0};
			res_pos_q   <= '{default: '0};
			res_sat_q   <= 1'b0;
			out_valid_q <= 1'b0;
			drag_q      <= pdg_pkg::DRAG_RESET;
			dt_q        <= '0;
			sumsq_q     <= '0;
			k_q         <= '0;
			gdt_q       <= '0;
			idx_q       <= '0;
			sat_q       <= 1'b0;
			vneg_q      <= 1'b0;
			go_q        <= 1'b0;
			rgo_q       <= 1'b0;
			op_a_q      <= '0;
			op_b_q      <= '0;
		end else begin
			go_q  <= 1'b0;
			rgo_q <= 1'b0;
			if (cfg.valid) begin
				drag_q <= cfg.drag_coefficient;
			end
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						sat_q <= 1'b0;
						if (item.cmd) begin
							vel_q[0] <= item.launch_vel_x;
							vel_q[1] <= item.launch_vel_y;
							vel_q[2] <= item.launch_vel_z;
							pos_q[0] <= item.launch_pos_x;
							pos_q[1] <= item.launch_pos_y;
							pos_q[2] <= item.launch_pos_z;
							state_q  <= ST_DONE;
						end else begin
							dt_q    <= item.time_step;
							sumsq_q <= '0;
							idx_q   <= '0;
							op_a_q  <= pdg_pkg::MUL_A_W'(mag_next);
							op_b_q  <= mag_next;
							go_q    <= 1'b1;
							state_q <= ST_SQ;
						end
					end
				end
				ST_SQ: begin
					if (mul_done) begin
						sumsq_q  <= sumsq_q + mul_p[pdg_pkg::ROOT_IN_W-1:0];
						vel_q[0] <= vel_q[1];
						vel_q[1] <= vel_q[2];
						vel_q[2] <= vel_q[0];
						if (idx_q == 2'd2) begin
							rgo_q   <= 1'b1;
							state_q <= ST_ROOT;
						end else begin
							idx_q  <= idx_q + 1'b1;
							op_a_q <= pdg_pkg::MUL_A_W'(mag_next);
							op_b_q <= mag_next;
							go_q   <= 1'b1;
						end
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						op_a_q  <= pdg_pkg::MUL_A_W'(root);
						op_b_q  <= pdg_pkg::MUL_B_W'(drag_q);
						go_q    <= 1'b1;
						state_q <= ST_DRAG;
					end
				end
				ST_DRAG: begin
					if (mul_done) begin
						op_a_q  <= mul_p[pdg_pkg::MUL_A_W+7:8];
						op_b_q  <= pdg_pkg::MUL_B_W'(dt_q);
						go_q    <= 1'b1;
						state_q <= ST_DT;
					end
				end
				ST_DT: begin
					if (mul_done) begin
						k_q     <= mul_p[pdg_pkg::MUL_A_W+15:16];
						op_a_q  <= pdg_pkg::MUL_A_W'(pdg_pkg::GRAVITY_Q16);
						op_b_q  <= pdg_pkg::MUL_B_W'(dt_q);
						go_q    <= 1'b1;
						state_q <= ST_GRAV;
					end
				end
				ST_GRAV: begin
					if (mul_done) begin
						gdt_q   <= mul_p[pdg_pkg::GDT_W+15:16];
						idx_q   <= '0;
						op_a_q  <= k_q;
						op_b_q  <= mag_next;
						go_q    <= 1'b1;
						state_q <= ST_LOSS;
					end
				end
				ST_LOSS: begin
					if (mul_done) begin
						vnew_q[0] <= vnew_q[1];
						vnew_q[1] <= vnew_q[2];
						vnew_q[2] <= vval;
						vel_q[0]  <= vel_q[1];
						vel_q[1]  <= vel_q[2];
						vel_q[2]  <= vel_q[0];
						sat_q     <= sat_q | vclip;
						go_q      <= 1'b1;
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							op_a_q  <= pdg_pkg::MUL_A_W'(vsum_mag);
							op_b_q  <= pdg_pkg::MUL_B_W'(dt_q);
							vneg_q  <= vsum[VW];
							state_q <= ST_POS;
						end else begin
							idx_q  <= idx_q + 1'b1;
							op_a_q <= k_q;
							op_b_q <= mag_next;
						end
					end
				end
				ST_POS: begin
					if (mul_done) begin
						pos_q[0]  <= pos_q[1];
						pos_q[1]  <= pos_q[2];
						pos_q[2]  <= pval;
						vel_q[0]  <= vel_q[1];
						vel_q[1]  <= vel_q[2];
						vel_q[2]  <= vnew_q[0];
						vnew_q[0] <= vnew_q[1];
						vnew_q[1] <= vnew_q[2];
						vnew_q[2] <= vnew_q[0];
						sat_q     <= sat_q | pclip;
						if (idx_q == 2'd2) begin
							state_q <= ST_DONE;
						end else begin
							idx_q  <= idx_q + 1'b1;
							op_a_q <= pdg_pkg::MUL_A_W'(vsum_mag);
							op_b_q <= pdg_pkg::MUL_B_W'(dt_q);
							vneg_q <= vsum[VW];
							go_q   <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || result.ready) begin
						res_vel_q   <= vel_q;
						res_pos_q   <= pos_q;
						res_sat_q   <= sat_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/pdg_smul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, unsigned 48 x 32.
// Depends on pdg_pkg.
`timescale 1ns / 1ps

module pdg_smul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pdg_pkg::MUL_A_W-1:0]   a,
	input  logic [pdg_pkg::MUL_B_W-1:0]   b,
	output logic                          done,
	output logic [pdg_pkg::MUL_P_W-1:0]   p
);

	localparam int unsigned CNT_W = $clog2(pdg_pkg::MUL_STEPS);

	logic [pdg_pkg::MUL_A_W-1:0] a_q;
	logic [pdg_pkg::MUL_B_W-1:0] b_q;
	logic [pdg_pkg::MUL_A_W-1:0] hi_q;
	logic [pdg_pkg::MUL_B_W-1:0] lo_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [pdg_pkg::MUL_A_W:0]   sum;

	assign sum  = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);
	assign p    = {hi_q, lo_q};
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q    <= '0;
			b_q    <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q   <= a;
				b_q   <= b;
				hi_q  <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				hi_q  <= sum[pdg_pkg::MUL_A_W:1];
				lo_q  <= {sum[0], lo_q[pdg_pkg::MUL_B_W-1:1]};
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(pdg_pkg::MUL_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/pdg_isqrt.sv =====
// Integer square root of a 64-bit value, one root bit per cycle.
// Depends on pdg_pkg.
`timescale 1ns / 1ps

module pdg_isqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [pdg_pkg::ROOT_IN_W-1:0]   x,
	output logic                            done,
	output logic [pdg_pkg::ROOT_W-1:0]      root
);

	localparam int unsigned CNT_W = $clog2(pdg_pkg::ROOT_STEPS);

	logic [pdg_pkg::ROOT_IN_W-1:0] x_q;
	logic [pdg_pkg::ROOT_IN_W-1:0] r_q;
	logic [pdg_pkg::ROOT_IN_W-1:0] bit_q;
	logic [pdg_pkg::ROOT_IN_W-1:0] trial;
	logic [CNT_W-1:0]              cnt_q;
	logic                          run_q;
	logic                          done_q;

	assign trial = r_q + bit_q;
	assign done  = done_q;
	assign root  = r_q[pdg_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			r_q    <= '0;
			bit_q  <= '0;
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q   <= x;
				r_q   <= '0;
				bit_q <= {2'b01, {(pdg_pkg::ROOT_IN_W-2){1'b0}}};
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(pdg_pkg::ROOT_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/pdg_checker.sv =====
// Port-level checks for the projectile step unit, bound to the top level.
// Depends on pdg_pkg and projectile_drag_gravity_step_unit.
`timescale 1ns / 1ps

module pdg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             item_valid,
	input logic                             item_ready,
	input logic                             item_cmd,
	input logic [pdg_pkg::VEL_W-1:0]        launch_vel_x,
	input logic [pdg_pkg::POS_W-1:0]        launch_pos_z,
	input logic                             result_valid,
	input logic                             result_ready,
	input logic [pdg_pkg::VEL_W-1:0]        vel_x,
	input logic [pdg_pkg::POS_W-1:0]        pos_z,
	input logic                             saturated
);

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted back to back");

	// launch result echoes the loaded vel_x and pos_z, unclipped
	a_launch_echo: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_cmd && !result_valid |=> ##1
		(result_valid && vel_x == $past(launch_vel_x, 2) &&
		 pos_z == $past(launch_pos_z, 2) && !saturated))
		else $error("launch result does not match launch transaction");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before transaction");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
		$stable(vel_x) && $stable(pos_z) && $stable(saturated))
		else $error("result payload changed while stalled");

endmodule

bind projectile_drag_gravity_step_unit pdg_checker u_pdg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_cmd     (item.cmd),
	.launch_vel_x (item.launch_vel_x),
	.launch_pos_z (item.launch_pos_z),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.vel_x        (result.vel_x),
	.pos_z        (result.pos_z),
	.saturated    (result.saturated)
);

// ===== tb/sv/tb_projectile_drag_gravity_step_unit.sv =====
// Self-checking bench for projectile_drag_gravity_step_unit: directed table, then random
// launch/step sequences over several drag settings, checked against an inline predictor.
// Depends on pdg_pkg, pdg_ifs and the unit under test.
`timescale 1ns / 1ps

module tb_projectile_drag_gravity_step_unit;

	typedef enum logic {CMD_STEP = 1'b0, CMD_LAUNCH = 1'b1} flight_op_t;

	typedef struct packed {
		flight_op_t                op;
		logic [pdg_pkg::DT_W-1:0]  dt;
		logic [pdg_pkg::VEL_W-1:0] vx, vy, vz;
		logic [pdg_pkg::POS_W-1:0] px, py, pz;
	} flight_cmd_t;

	typedef struct packed {
		logic [pdg_pkg::VEL_W-1:0] vx, vy, vz;
		logic [pdg_pkg::POS_W-1:0] px, py, pz;
		logic                      sat;
	} flight_state_t;

	typedef struct packed {
		flight_cmd_t   c;
		logic          typed;
		flight_state_t want;
	} flight_row_t;

	localparam longint VEL_HI = longint'($signed(pdg_pkg::VEL_MAX));
	localparam longint VEL_LO = longint'($signed(pdg_pkg::VEL_MIN));
	localparam longint POS_HI = longint'($signed(pdg_pkg::POS_MAX));
	localparam longint POS_LO = longint'($signed(pdg_pkg::POS_MIN));
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 213;
	localparam int HOLD_CYCLES = 3000;
	localparam int MAX_PRINTS = 40;

	logic clk;
	logic arst_n;

	pdg_item_if   item_ch();
	pdg_result_if res_ch();
	pdg_cfg_if    cfg_ch();

	projectile_drag_gravity_step_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	// predictor state
	longint          vel_st[3];
	longint          pos_st[3];
	logic [pdg_pkg::DRAG_W-1:0] drag_st;

	flight_state_t state_due_q[$];

	int n_sent;
	int n_results;
	int n_errors;
	int n_launch;
	int n_step;
	int n_clipped;
	int n_drag_writes;
	int src_idle_pct;
	int snk_idle_pct;
	logic hold_request;
	logic hold_served;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Timeout waiting for the unit to finish");
		$display("Test completed with failures");
		$finish;
	end

	function automatic longint unsigned abs_u64(input longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	function automatic longint unsigned root64(input longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clip_to(input longint x, input longint lo, input longint hi,
			inout logic hit);
		if (x > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (x < lo) begin
			hit = 1'b1;
			return lo;
		end
		return x;
	endfunction

	// Applies one transaction to the predicted state and returns the expected result.
	function automatic flight_state_t advance_flight(input flight_cmd_t c);
		flight_state_t   r;
		longint          old_v[3];
		longint unsigned mag, sumsq, spd, k, kh, kl, gdt, loss;
		longint          nv, delta;
		logic            hit;
		hit = 1'b0;
		if (c.op == CMD_LAUNCH) begin
			n_launch++;
			vel_st[0] = longint'($signed(c.vx));
			vel_st[1] = longint'($signed(c.vy));
			vel_st[2] = longint'($signed(c.vz));
			pos_st[0] = longint'($signed(c.px));
			pos_st[1] = longint'($signed(c.py));
			pos_st[2] = longint'($signed(c.pz));
		end else begin
			n_step++;
			sumsq = 0;
			for (int i = 0; i < 3; i++) begin
				old_v[i] = vel_st[i];
				mag = abs_u64(vel_st[i]);
				sumsq += mag * mag;
			end
			spd = root64(sumsq);
			k = (((spd * 64'(drag_st)) >> 8) * 64'(c.dt)) >> 16;
			kh = k >> 32;
			kl = k & 64'hFFFF_FFFF;
			gdt = (64'(pdg_pkg::GRAVITY_Q16) * 64'(c.dt)) >> 16;
			for (int i = 0; i < 3; i++) begin
				mag = abs_u64(old_v[i]);
				loss = mag * kh + ((mag * kl) >> 32);
				nv = (old_v[i] < 0) ? old_v[i] + longint'(loss) : old_v[i] - longint'(loss);
				if (i == 2)
					nv -= longint'(gdt);
				vel_st[i] = clip_to(nv, VEL_LO, VEL_HI, hit);
			end
			for (int i = 0; i < 3; i++) begin
				delta = ((old_v[i] + vel_st[i]) * longint'(c.dt)) >>> 17;
				pos_st[i] = clip_to(pos_st[i] + delta, POS_LO, POS_HI, hit);
			end
		end
		if (hit)
			n_clipped++;
		r.vx = vel_st[0][pdg_pkg::VEL_W-1:0];
		r.vy = vel_st[1][pdg_pkg::VEL_W-1:0];
		r.vz = vel_st[2][pdg_pkg::VEL_W-1:0];
		r.px = pos_st[0][pdg_pkg::POS_W-1:0];
		r.py = pos_st[1][pdg_pkg::POS_W-1:0];
		r.pz = pos_st[2][pdg_pkg::POS_W-1:0];
		r.sat = hit;
		return r;
	endfunction

	function automatic flight_cmd_t launch_of(input logic [pdg_pkg::VEL_W-1:0] vx, vy, vz,
			input logic [pdg_pkg::POS_W-1:0] px, py, pz);
		flight_cmd_t c;
		c.op = CMD_LAUNCH;
		c.dt = pdg_pkg::DT_W'($urandom);
		c.vx = vx;
		c.vy = vy;
		c.vz = vz;
		c.px = px;
		c.py = py;
		c.pz = pz;
		return c;
	endfunction

	function automatic flight_cmd_t step_of(input logic [pdg_pkg::DT_W-1:0] dt);
		flight_cmd_t c;
		c.op = CMD_STEP;
		c.dt = dt;
		c.vx = $urandom;
		c.vy = $urandom;
		c.vz = $urandom;
		c.px = pdg_pkg::POS_W'({$urandom, $urandom});
		c.py = pdg_pkg::POS_W'({$urandom, $urandom});
		c.pz = pdg_pkg::POS_W'({$urandom, $urandom});
		return c;
	endfunction

	// a launch returns its own values, unclipped
	function automatic flight_state_t echo_of(input flight_cmd_t c);
		flight_state_t r;
		r.vx = c.vx;
		r.vy = c.vy;
		r.vz = c.vz;
		r.px = c.px;
		r.py = c.py;
		r.pz = c.pz;
		r.sat = 1'b0;
		return r;
	endfunction

	function automatic logic [pdg_pkg::VEL_W-1:0] rand_vel();
		logic [pdg_pkg::VEL_W-1:0] m;
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return pdg_pkg::VEL_MAX;
			2: return pdg_pkg::VEL_MIN;
			default: begin
				m = $urandom_range(0, 600 << 16);
				return $urandom_range(0, 1) ? -m : m;
			end
		endcase
	endfunction

	function automatic logic [pdg_pkg::POS_W-1:0] rand_pos();
		logic [pdg_pkg::POS_W-1:0] m;
		case ($urandom_range(0, 7))
			0: return pdg_pkg::POS_W'({$urandom, $urandom});
			1: return pdg_pkg::POS_MAX;
			2: return pdg_pkg::POS_MIN;
			default: begin
				m = pdg_pkg::POS_W'($urandom_range(0, 20000 << 16));
				return $urandom_range(0, 1) ? -m : m;
			end
		endcase
	endfunction

	function automatic logic [pdg_pkg::DT_W-1:0] rand_dt();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return pdg_pkg::DT_W'($urandom_range(0, 65535));
			default: return pdg_pkg::DT_W'($urandom_range(1, 16'h0800));
		endcase
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("%0t ns: result %0d %s: got %h, expected %h", $time, n_results, what,
				got, want);
	endtask

	task automatic send_item(input flight_cmd_t c, input logic typed,
			input flight_state_t want);
		flight_state_t pred;
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.cmd          <= c.op;
		item_ch.time_step    <= c.dt;
		item_ch.launch_vel_x <= c.vx;
		item_ch.launch_vel_y <= c.vy;
		item_ch.launch_vel_z <= c.vz;
		item_ch.launch_pos_x <= c.px;
		item_ch.launch_pos_y <= c.py;
		item_ch.launch_pos_z <= c.pz;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		n_sent++;
		pred = advance_flight(c);
		state_due_q.push_back(typed ? want : pred);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		while (n_results != n_sent)
			@(posedge clk);
	endtask

	task automatic write_drag(input logic [pdg_pkg::DRAG_W-1:0] d);
		cfg_ch.valid            <= 1'b1;
		cfg_ch.drag_coefficient <= d;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		drag_st = d;
		n_drag_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		hold_served = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				res_ch.ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end
			res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		flight_state_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			n_results++;
			if (state_due_q.size() == 0) begin
				note_mismatch("unexpected transaction", {res_ch.vel_x, res_ch.vel_y}, '0);
			end else begin
				want = state_due_q.pop_front();
				if (res_ch.vel_x !== want.vx) note_mismatch("vel_x", res_ch.vel_x, want.vx);
				if (res_ch.vel_y !== want.vy) note_mismatch("vel_y", res_ch.vel_y, want.vy);
				if (res_ch.vel_z !== want.vz) note_mismatch("vel_z", res_ch.vel_z, want.vz);
				if (res_ch.pos_x !== want.px) note_mismatch("pos_x", res_ch.pos_x, want.px);
				if (res_ch.pos_y !== want.py) note_mismatch("pos_y", res_ch.pos_y, want.py);
				if (res_ch.pos_z !== want.pz) note_mismatch("pos_z", res_ch.pos_z, want.pz);
				if (res_ch.saturated !== want.sat)
					note_mismatch("saturated", res_ch.saturated, want.sat);
			end
		end
	end

	initial begin
		flight_row_t                plan[$];
		flight_cmd_t                c1;
		logic [pdg_pkg::DRAG_W-1:0] d;
		int                         in_phase;
		int                         n_hops;
		logic                       paused;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_STEP;
		item_ch.time_step = '0;
		item_ch.launch_vel_x = '0;
		item_ch.launch_vel_y = '0;
		item_ch.launch_vel_z = '0;
		item_ch.launch_pos_x = '0;
		item_ch.launch_pos_y = '0;
		item_ch.launch_pos_z = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.drag_coefficient = '0;
		n_sent = 0;
		n_results = 0;
		n_errors = 0;
		n_launch = 0;
		n_step = 0;
		n_clipped = 0;
		n_drag_writes = 0;
		src_idle_pct = 18;
		snk_idle_pct = 72;
		hold_request = 1'b0;
		drag_st = pdg_pkg::DRAG_RESET;
		for (int i = 0; i < 3; i++) begin
			vel_st[i] = 0;
			pos_st[i] = 0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: state after reset, extremes, reversal under drag at extreme speed, clipping both ways
		plan.push_back({step_of('0), 1'b1, flight_state_t'('0)});
		plan.push_back({step_of('1), 1'b0, flight_state_t'('0)});
		plan.push_back({step_of('0), 1'b0, flight_state_t'('0)});
		c1 = launch_of(pdg_pkg::VEL_MAX, pdg_pkg::VEL_MAX, pdg_pkg::VEL_MAX,
			pdg_pkg::POS_MAX, pdg_pkg::POS_MAX, pdg_pkg::POS_MAX);
		plan.push_back({c1, 1'b1, echo_of(c1)});
		plan.push_back({step_of('0), 1'b1, echo_of(c1)});
		plan.push_back({step_of('1), 1'b0, flight_state_t'('0)});
		c1 = launch_of(pdg_pkg::VEL_MIN, pdg_pkg::VEL_MIN, pdg_pkg::VEL_MIN,
			pdg_pkg::POS_MIN, pdg_pkg::POS_MIN, pdg_pkg::POS_MIN);
		plan.push_back({c1, 1'b1, echo_of(c1)});
		plan.push_back({step_of('1), 1'b0, flight_state_t'('0)});
		c1 = launch_of('0, '0, '0, '0, '0, '0);
		plan.push_back({c1, 1'b1, echo_of(c1)});
		plan.push_back({step_of(16'd1), 1'b0, flight_state_t'('0)});
		c1 = launch_of(32'd16384000, 32'(-2654208), 32'd19660800, '0, 48'(-65536000),
			48'd655360);
		plan.push_back({c1, 1'b1, echo_of(c1)});
		plan.push_back({step_of('0), 1'b1, echo_of(c1)});
		plan.push_back({step_of(16'h0CCD), 1'b0, flight_state_t'('0)});
		plan.push_back({step_of(16'h0CCD), 1'b0, flight_state_t'('0)});
		plan.push_back({step_of(16'h8000), 1'b0, flight_state_t'('0)});
		plan.push_back({step_of(16'h0001), 1'b0, flight_state_t'('0)});
		plan.push_back({step_of('1), 1'b0, flight_state_t'('0)});
		c1 = launch_of(32'd1, '1, '1, '1, 48'd1, pdg_pkg::POS_MIN);
		plan.push_back({c1, 1'b1, echo_of(c1)});
		plan.push_back({step_of('1), 1'b0, flight_state_t'('0)});
		c1 = launch_of('0, '0, pdg_pkg::VEL_MAX, '0, '0, pdg_pkg::POS_MAX);
		plan.push_back({c1, 1'b1, echo_of(c1)});
		plan.push_back({step_of('1), 1'b0, flight_state_t'('0)});
		c1 = launch_of(32'h5555_5555, 32'hAAAA_AAAA, '0, 48'h5555_5555_5555,
			48'hAAAA_AAAA_AAAA, '0);
		plan.push_back({c1, 1'b1, echo_of(c1)});
		plan.push_back({step_of(16'hAAAA), 1'b0, flight_state_t'('0)});
		plan.push_back({step_of(16'h5555), 1'b0, flight_state_t'('0)});

		write_drag(pdg_pkg::DRAG_RESET);
		foreach (plan[i])
			send_item(plan[i].c, plan[i].typed, plan[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: d = '1;
				1: d = '0;
				2: d = pdg_pkg::DRAG_W'(1);
				3: d = pdg_pkg::DRAG_W'($urandom);
				4: d = pdg_pkg::DRAG_RESET;
				default: d = pdg_pkg::DRAG_W'($urandom_range(0, 200000));
			endcase
			write_drag(d);
			src_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 72 : 0;
			snk_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 18 : 0;
			if (ph == 2)
				hold_request = 1'b1;
			in_phase = 0;
			paused = 1'b0;
			while (in_phase < PHASE_ITEMS) begin
				if (ph == 4 && !paused && in_phase >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					wait_drained();
				end
				if ($urandom_range(0, 9) == 0) begin
					c1 = step_of(pdg_pkg::DT_W'($urandom));
					c1.op = flight_op_t'($urandom_range(0, 1));
					send_item(c1, 1'b0, flight_state_t'('0));
					in_phase++;
				end else begin
					send_item(launch_of(rand_vel(), rand_vel(), rand_vel(), rand_pos(),
						rand_pos(), rand_pos()), 1'b0, flight_state_t'('0));
					in_phase++;
					n_hops = $urandom_range(1, 10);
					for (int s = 0; s < n_hops; s++) begin
						send_item(step_of(rand_dt()), 1'b0, flight_state_t'('0));
						in_phase++;
					end
				end
			end
		end

		wait_drained();
		repeat (600) @(posedge clk);
		if (state_due_q.size() != 0)
			note_mismatch("missing transactions", state_due_q.size(), 0);
		$display("Ran %0d launches and %0d steps over %0d drag settings; %0d results clipped.",
			n_launch, n_step, n_drag_writes, n_clipped);
		$display("Stalls skewed each way then none, one %0d-cycle output hold-off, %0d errors.",
			HOLD_CYCLES, n_errors);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
src/pdg_pkg.sv
src/pdg_ifs.sv
src/pdg_smul.sv
src/pdg_isqrt.sv
src/projectile_drag_gravity_step_unit.sv
src/pdg_checker.sv
tb/sv/tb_projectile_drag_gravity_step_unit.sv
